FILE: sv/nlms_pkg.sv
// Package for the NLMS adaptive FIR core: sizes, register indexes,
// controller state type and the command/status words between ctrl and datapath.
// No dependencies.
package nlms_pkg;

  localparam int MAX_TAPS = 32;
  localparam int IDX_W    = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);
  localparam int ACC_W    = 48 + $clog2(MAX_TAPS);
  localparam int ENERGY_W = 32 + $clog2(MAX_TAPS);
  localparam int Q_W      = 48;
  localparam int DIV_STEPS = 48;

  localparam logic [1:0] REG_STEP_SIZE   = 2'd0;
  localparam logic [1:0] REG_REGULARIZER = 2'd1;
  localparam logic [1:0] REG_TAP_COUNT   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_MAC_DRAIN,
    ST_ROUND,
    ST_PROD,
    ST_CHECK,
    ST_DIV,
    ST_GAIN,
    ST_UPD,
    ST_UPD_DRAIN,
    ST_FINISH
  } nlms_state_t;

  typedef struct packed {
    logic load;
    logic mac_issue;
    logic round;
    logic prod;
    logic check;
    logic div_step;
    logic gain;
    logic upd_issue;
    logic finish;
  } nlms_cmd_t;

  typedef struct packed {
    logic warm;
    logic k_last;
    logic div_last;
    logic div_skip;
  } nlms_sts_t;

  // tap count zero acts as one, above the maximum as the maximum
  function automatic logic [CNT_W-1:0] taps_in_use(input logic [5:0] tc);
    logic [CNT_W-1:0] n;
    if (tc == 6'd0) n = CNT_W'(1);
    else if (int'(tc) > MAX_TAPS) n = CNT_W'(MAX_TAPS);
    else n = CNT_W'(tc);
    return n;
  endfunction

endpackage

FILE: sv/nlms_if.sv
// Handshake interfaces for the sample and result channels.
// Depends on nothing.
interface nlms_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_sample;
  logic signed [15:0] desired_sample;
  modport source (output valid, in_sample, desired_sample, input ready);
  modport sink   (input valid, in_sample, desired_sample, output ready);
endinterface

interface nlms_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] filter_out;
  logic signed [16:0] error_out;
  logic               warming;
  modport source (output valid, filter_out, error_out, warming, input ready);
  modport sink   (input valid, filter_out, error_out, warming, output ready);
endinterface

FILE: sv/nlms_ctrl.sv
// Sequencer for the NLMS core: steps the datapath through MAC pass,
// divide and weight update. Uses nlms_pkg.
module nlms_ctrl import nlms_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  nlms_sts_t sts,
  output nlms_cmd_t cmd
);

  nlms_state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = sts.warm ? ST_FINISH : ST_MAC;
      ST_MAC:       if (sts.k_last) state_next = ST_MAC_DRAIN;
      ST_MAC_DRAIN: state_next = ST_ROUND;
      ST_ROUND:     state_next = ST_PROD;
      ST_PROD:      state_next = ST_CHECK;
      ST_CHECK:     state_next = sts.div_skip ? ST_GAIN : ST_DIV;
      ST_DIV:       if (sts.div_last) state_next = ST_GAIN;
      ST_GAIN:      state_next = ST_UPD;
      ST_UPD:       if (sts.k_last) state_next = ST_UPD_DRAIN;
      ST_UPD_DRAIN: state_next = ST_FINISH;
      ST_FINISH:    if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = (state == ST_IDLE);
    cmd.load      = (state == ST_IDLE) && in_valid;
    cmd.mac_issue = (state == ST_MAC);
    cmd.round     = (state == ST_ROUND);
    cmd.prod      = (state == ST_PROD);
    cmd.check     = (state == ST_CHECK);
    cmd.div_step  = (state == ST_DIV);
    cmd.gain      = (state == ST_GAIN);
    cmd.upd_issue = (state == ST_UPD);
    cmd.finish    = (state == ST_FINISH) && out_free;
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state != ST_IDLE) else $error("accept did not start work");
  a_finish_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("result word not presented");
  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("more than one datapath command");

endmodule

FILE: sv/nlms_dp.sv
// Datapath of the NLMS core: delay line, weights, shared MAC, bit-serial
// divider and weight update. Driven by nlms_ctrl; uses nlms_pkg.
module nlms_dp import nlms_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  nlms_cmd_t          cmd,
  output nlms_sts_t          sts,
  input  logic [15:0]        step_size,
  input  logic [15:0]        regularizer,
  input  logic [5:0]         tap_count,
  input  logic signed [15:0] in_sample,
  input  logic signed [15:0] desired_sample,
  output logic signed [15:0] filter_out,
  output logic signed [16:0] error_out,
  output logic               warming
);

  localparam logic [Q_W-1:0] G_MAX = Q_W'(1) << 47;

  logic signed [15:0]       delay_line [MAX_TAPS];
  logic signed [31:0]       tap_weights [MAX_TAPS];
  logic [CNT_W-1:0]         seen_count;
  logic [CNT_W-1:0]         n_lat;
  logic                     warm_lat;
  logic signed [15:0]       xs, ds;
  logic [IDX_W-1:0]         k, ku;
  logic signed [47:0]       prod_m;
  logic [31:0]              prod_e;
  logic                     mac_pv, upd_pv;
  logic signed [ACC_W-1:0]  acc;
  logic [ENERGY_W-1:0]      energy;
  logic signed [15:0]       y;
  logic signed [16:0]       e;
  logic signed [33:0]       p;
  logic [31:0]              mag;
  logic [ENERGY_W-1:0]      rem;
  logic [47:0]              dsh;
  logic [Q_W-1:0]           q;
  logic [5:0]               dcnt;
  logic signed [Q_W:0]      g;
  logic signed [64:0]       prod_u;

  // rounding and saturation of the sum
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [ACC_W-31:0] y_wide;
  logic signed [15:0]       y_sat;
  // divider step
  logic [ENERGY_W:0]        trial;
  logic                     ge;
  // magnitude of mu*e and overflow test
  logic [32:0]              p_abs;
  logic [ENERGY_W+18:0]     e_sh;
  // weight update
  logic signed [64:0]       u_rnd;
  logic signed [49:0]       d;
  logic signed [50:0]       w_new;
  logic signed [31:0]       w_sat;
  logic [Q_W-1:0]           q_c;

  assign sts.warm     = seen_count < taps_in_use(tap_count);
  assign sts.k_last   = {1'b0, k} == CNT_W'(n_lat - 1'b1);
  assign sts.div_last = (dcnt == 6'd0);
  assign sts.div_skip = (energy == '0) || ({19'd0, mag} >= e_sh);

  assign e_sh   = {energy, 19'd0};
  assign p_abs  = p[33] ? 33'(-p) : 33'(p);
  assign mag    = p_abs[31:0];
  assign acc_rnd = acc + ACC_W'(1 << 29);
  assign y_wide = (ACC_W-30)'(acc_rnd >>> 30);
  assign y_sat  = (y_wide > 32767) ? 16'sd32767 :
                  (y_wide < -32768) ? -16'sd32768 : 16'(y_wide);
  assign trial  = {rem, dsh[47]};
  assign ge     = trial >= {1'b0, energy};
  assign q_c    = (q > G_MAX) ? G_MAX : q;
  assign u_rnd  = prod_u + 65'sd16384;
  assign d      = 50'(u_rnd >>> 15);
  assign w_new  = 51'(tap_weights[ku]) + 51'(d);
  assign w_sat  = (w_new > 51'sd2147483647) ? 32'sh7fffffff :
                  (w_new < -51'sd2147483648) ? 32'sh80000000 : 32'(w_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
      mac_pv     <= 1'b0;
      upd_pv     <= 1'b0;
      for (int i = 0; i < MAX_TAPS; i++) begin
        delay_line[i]  <= '0;
        tap_weights[i] <= '0;
      end
    end else begin
      mac_pv <= cmd.mac_issue;
      upd_pv <= cmd.upd_issue;
      if (upd_pv) tap_weights[ku] <= w_sat;
      if (cmd.finish) begin
        for (int i = MAX_TAPS - 1; i > 0; i--) delay_line[i] <= delay_line[i-1];
        delay_line[0] <= xs;
        if (seen_count < CNT_W'(MAX_TAPS)) seen_count <= seen_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs       <= in_sample;
      ds       <= desired_sample;
      n_lat    <= taps_in_use(tap_count);
      warm_lat <= sts.warm;
      k        <= '0;
      acc      <= '0;
      energy   <= ENERGY_W'(regularizer);
      y        <= '0;
      e        <= '0;
    end
    if (cmd.mac_issue) begin
      prod_m <= tap_weights[k] * delay_line[k];
      prod_e <= 32'(32'(delay_line[k]) * 32'(delay_line[k]));
      k      <= k + 1'b1;
    end
    if (mac_pv) begin
      acc    <= acc + ACC_W'(prod_m);
      energy <= energy + ENERGY_W'(prod_e);
    end
    if (cmd.round) begin
      y <= y_sat;
      e <= 17'(ds) - 17'(y_sat);
    end
    if (cmd.prod) p <= $signed({18'd0, step_size}) * 34'(e);
    if (cmd.check) begin
      k    <= '0;
      dcnt <= 6'(DIV_STEPS - 1);
      rem  <= ENERGY_W'(mag[31:19]);
      dsh  <= {mag[18:0], 29'd0};
      if (energy == '0) q <= '0;
      else if ({19'd0, mag} >= e_sh) q <= G_MAX;
      else q <= '0;
    end
    if (cmd.div_step) begin
      rem  <= ge ? ENERGY_W'(trial - {1'b0, energy}) : ENERGY_W'(trial);
      dsh  <= {dsh[46:0], 1'b0};
      q    <= {q[Q_W-2:0], ge};
      dcnt <= dcnt - 1'b1;
    end
    if (cmd.gain) g <= p[33] ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
    if (cmd.upd_issue) begin
      prod_u <= 65'(g) * 65'(delay_line[k]);
      ku     <= k;
      k      <= k + 1'b1;
    end
    if (cmd.finish) begin
      filter_out <= y;
      error_out  <= e;
      warming    <= warm_lat;
    end
  end

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen_count <= CNT_W'(MAX_TAPS)) else $error("sample count past maximum");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> rem < energy) else $error("divider remainder out of range");
  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.gain |=> (g <= $signed({1'b0, G_MAX})) && (g >= -$signed({1'b0, G_MAX})))
    else $error("gain beyond clamp");

endmodule

FILE: sv/nlms_adaptive_fir_core.sv
// Top level of the NLMS adaptive FIR core: config registers, sequencer and
// datapath. Uses nlms_pkg, nlms_if, nlms_ctrl, nlms_dp.
//
//  channel   dir  word
//  samples   in   in_sample, desired_sample (Q1.15)
//  results   out  filter_out, error_out, warming
//  cfg_*     in   write enable, register index, 16-bit data
//
// One word at a time. After warm-up an item runs one MAC pass over the
// N taps in use, rounding, the mu*e product, a clamp check, 48 steps of
// the bit-serial divider for the gain, the gain step, one update pass
// and the finishing step; with zero energy or a clamped gain the divider
// is skipped. During warm-up an item goes straight to the finishing step.
// The result sits in an output register; the next sample is taken while a
// result waits there, and a stalled result only holds the finishing step.
// Synchronous reset clears weights, delay line and count, and sets the config registers to their defaults.
module nlms_adaptive_fir_core import nlms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  nlms_in_if.sink     samples,
  nlms_out_if.source  results,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] step_size;
  logic [15:0] regularizer;
  logic [5:0]  tap_count;
  nlms_cmd_t   cmd;
  nlms_sts_t   sts;

  // config registers; index three is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size   <= 16'd655;
      regularizer <= 16'd11;
      tap_count   <= 6'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_SIZE:   step_size   <= cfg_data;
        REG_REGULARIZER: regularizer <= cfg_data;
        REG_TAP_COUNT:   tap_count   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  nlms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  nlms_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .step_size      (step_size),
    .regularizer    (regularizer),
    .tap_count      (tap_count),
    .in_sample      (samples.in_sample),
    .desired_sample (samples.desired_sample),
    .filter_out     (results.filter_out),
    .error_out      (results.error_out),
    .warming        (results.warming)
  );

  a_warm_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.warming |-> results.filter_out == 0 && results.error_out == 0)
    else $error("nonzero result during warm-up");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("second word taken while busy");
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(!samples.ready))
    else $error("result without work");

endmodule

FILE: dv/tb_nlms_adaptive_fir_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for nlms_adaptive_fir_core: drives sample words,
// predicts every result word with its own NLMS model and checks it.
// Depends on nlms_pkg, nlms_if and the core itself.
module tb_nlms_adaptive_fir_core;
  import nlms_pkg::*;

  // expected result word
  typedef struct {
    logic signed [15:0] y;
    logic signed [16:0] e;
    logic               warm;
  } nlms_result_t;

  // Bit-true NLMS predictor plus a queue of the result words it owes.
  class nlms_scoreboard;
    logic [15:0]        mu;
    logic [15:0]        eps;
    logic [5:0]         taps;
    logic signed [15:0] hist[MAX_TAPS];
    logic signed [31:0] wts[MAX_TAPS];
    int                 seen;
    nlms_result_t       owed[$];
    int                 mismatches;
    int                 checked;

    function void clear();
      mu = 16'd655; eps = 16'd11; taps = 6'd16; seen = 0;
      foreach (hist[k]) begin
        hist[k] = '0;
        wts[k]  = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_STEP_SIZE:   mu = val;
        REG_REGULARIZER: eps = val;
        REG_TAP_COUNT:   taps = val[5:0];
        default: ; // unused index, no effect
      endcase
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // one accepted sample word: compute its result word, adapt, shift in
    function void note_sample(logic signed [15:0] xs, logic signed [15:0] ds);
      int                n;
      longint            acc, y, e, p, g, d, w;
      longint unsigned   energy, mag, q;
      nlms_result_t      r;
      n = (taps == 0) ? 1 : ((taps > MAX_TAPS) ? MAX_TAPS : int'(taps));
      r.warm = (seen < n);
      y = 0; e = 0;
      if (!r.warm) begin
        acc = 0;
        energy = longint'(eps);
        for (int k = 0; k < n; k++) begin
          acc += longint'(wts[k]) * longint'(hist[k]);
          energy += longint'(longint'(hist[k]) * longint'(hist[k]));
        end
        y = (acc + (longint'(1) <<< 29)) >>> 30;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        e = longint'(ds) - y;
        g = 0;
        if (energy != 0) begin
          p = longint'(mu) * e;
          mag = (p < 0) ? longint'(-p) : longint'(p);
          q = (mag << 29) / energy;
          if (q > (64'd1 << 47)) q = 64'd1 << 47;
          g = (p < 0) ? -longint'(q) : longint'(q);
        end
        for (int k = 0; k < n; k++) begin
          d = (g * longint'(hist[k]) + (longint'(1) <<< 14)) >>> 15;
          w = longint'(wts[k]) + d;
          if (w > 64'sd2147483647) w = 64'sd2147483647;
          if (w < -64'sd2147483648) w = -64'sd2147483648;
          wts[k] = w[31:0];
        end
      end
      for (int k = MAX_TAPS - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = xs;
      if (seen < MAX_TAPS) seen++;
      r.y = y[15:0];
      r.e = e[16:0];
      owed.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] y, logic signed [16:0] e, logic warm);
      nlms_result_t x;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: y=%0d e=%0d warming=%0b", y, e, warm);
        return;
      end
      x = owed.pop_front();
      if (y !== x.y || e !== x.e || warm !== x.warm) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: exp y=%0d e=%0d warming=%0b, got y=%0d e=%0d warming=%0b",
                   checked, x.y, x.e, x.warm, y, e, warm);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  nlms_in_if  samples();
  nlms_out_if results();

  nlms_adaptive_fir_core dut (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  nlms_scoreboard sb = new();
  int send_idle_pct  = 0;   // chance per cycle that the sender holds off
  int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  int idle_cycles    = 0;   // cycles with no word moved on either channel
  int words_in       = 0;
  localparam int WATCHDOG_LIMIT = 20000;

  // receiver: random back-pressure
  always @(posedge clk)
    results.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // monitor: sample pre-edge values; result check goes first, as a result
  // accepted on the same edge always belongs to an earlier sample word
  always @(posedge clk) begin
    if (!rst) begin
      if (results.valid && results.ready)
        sb.check_result(results.filter_out, results.error_out, results.warming);
      if (samples.valid && samples.ready) begin
        sb.note_sample(samples.in_sample, samples.desired_sample);
        words_in++;
      end
      if ((results.valid && results.ready) || (samples.valid && samples.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // register write, one per edge; the model follows at the same moment
  task automatic reg_write(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic reg_done();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every owed result has come, then let the core settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // send one sample word; valid stays high straight into the next word
  // unless the sender decides to hold off. Ready is looked at mid-cycle,
  // so the loop ends exactly on the accepting edge.
  task automatic send_word(logic signed [15:0] xs, logic signed [15:0] ds);
    logic taken;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    samples.valid          <= 1'b1;
    samples.in_sample      <= xs;
    samples.desired_sample <= ds;
    do begin
      @(negedge clk);
      taken = samples.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_stop();
    samples.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: rand_sample = 16'($urandom);
      1: rand_sample = 16'($urandom_range(0, 2047) - 1024);
      2: rand_sample = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: rand_sample = 16'($urandom_range(0, 255) - 128);
    endcase
  endfunction

  // phase table: mu, eps, tap count, sender idle %, receiver stall %
  int ph_mu[8]   = '{655, 65535, 1000, 0, 20000, 65535, 4000, 12345};
  int ph_eps[8]  = '{11, 65535, 0, 1, 300, 0, 65535, 7};
  int ph_taps[8] = '{0, 32, 63, 33, 8, 1, 16, 5};
  int ph_send[8] = '{0, 53, 0, 12, 0, 53, 0, 12};
  int ph_recv[8] = '{0, 0, 53, 12, 0, 0, 53, 12};

  initial begin
    logic signed [15:0] xs, ds, prev;
    samples.valid          = 1'b0;
    samples.in_sample      = '0;
    samples.desired_sample = '0;
    sb.clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: two taps, full step, no regulariser so that all-zero taps
    // hit the no-divide path, then sample and desired extremes
    reg_write(REG_TAP_COUNT, 16'd2);
    reg_write(REG_STEP_SIZE, 16'hffff);
    reg_write(REG_REGULARIZER, 16'd0);
    reg_done();
    repeat (4) send_word(16'sd0, 16'sd0);
    send_word(16'sd0, 16'sh7fff);
    send_word(16'sh7fff, 16'sh8000);
    send_word(16'sh7fff, 16'sh7fff);
    send_word(16'sh8000, 16'sh8000);
    send_word(16'sh8000, 16'sh7fff);
    send_word(16'sd1, 16'sh8000);
    send_word(-16'sd1, 16'sh7fff);
    for (int i = 0; i < 6; i++) send_word(16'sh7fff, 16'sh7fff);
    for (int i = 0; i < 6; i++) send_word(16'sh8000, 16'sh8000);
    send_word(16'sd0, 16'sd0);
    send_word(16'sd0, 16'sd0);
    send_stop();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      // unused register index must change nothing
      if (ph % 2 == 1) reg_write(2'd3, 16'($urandom));
      reg_write(REG_STEP_SIZE, 16'(ph_mu[ph]));
      reg_write(REG_REGULARIZER, 16'(ph_eps[ph]));
      reg_write(REG_TAP_COUNT, 16'(ph_taps[ph]));
      reg_done();
      send_idle_pct  = ph_send[ph];
      recv_stall_pct = ph_recv[ph];
      prev = '0;
      for (int i = 0; i < 165; i++) begin
        // mostly a loosely tracking desired signal so weights adapt, some noise
        xs = rand_sample();
        if ($urandom_range(0, 3) != 0)
          ds = (prev >>> 1) + 16'sh0000 + 16'($urandom_range(0, 63) - 32);
        else
          ds = rand_sample();
        prev = xs;
        send_word(xs, ds);
        // sender holds until the core has handed back everything
        if (ph == 4 && i == 80) begin
          send_stop();
          while (sb.pending() != 0) @(posedge clk);
        end
      end
      send_stop();
      drain();
    end

    recv_stall_pct = 0;
    repeat (200) @(posedge clk);
    $display("Run covered %0d sample words over 9 register settings (taps 0..63, mu and eps",
             words_in);
    $display("at both extremes) with idle, stall and hold-off patterns; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
